// ===== hdl/crh_pkg.sv =====
// Shared types, widths and codes for the circle/rectangle/point hit test.
// Used by the query channel interface, crh_front and circle_rect_point_hit_test.
`timescale 1ns / 1ps
`default_nettype none

package crh_pkg;

  // Coordinate width and the widths that follow from it.
  localparam int COORD_BITS = 16;
  localparam int DIFF_W     = COORD_BITS + 1;
  localparam int SQ_W       = 2 * COORD_BITS;
  localparam int RAD_W      = COORD_BITS - 1;
  localparam int R2_W       = 2 * RAD_W;
  localparam int SUM_W      = SQ_W + 2;
  localparam int CFG_IDX_W  = 2;

  // Query kinds.
  localparam logic ACT_RECT  = 1'b0;
  localparam logic ACT_POINT = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Z    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ZONE_RADIUS = 2'd3;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]     diff_t;
  typedef logic        [SQ_W-1:0]       sq_t;
  typedef logic        [RAD_W-1:0]      radius_t;
  typedef logic        [R2_W-1:0]       r2_t;
  typedef logic        [SUM_W-1:0]      sum_t;

  // Zone configuration as seen by the datapath.
  typedef struct packed {
    coord_t  center_x;
    coord_t  center_y;
    coord_t  center_z;
    radius_t zone_radius;
  } crh_cfg_t;

  // Operands handed from the front stages to the square stage.
  // Rectangle: op0/op1 are the clamped X/Z offsets, op2/op3 the Z offsets
  // of the lower and upper edges, op4/op5 the X offsets of the left and
  // right edges. Point: op0..op2 are the X, Y and Z offsets.
  // ctr_in flags a rectangle that contains the zone center.
  typedef struct packed {
    logic  act;
    logic  ctr_in;
    diff_t op0;
    diff_t op1;
    diff_t op2;
    diff_t op3;
    diff_t op4;
    diff_t op5;
  } crh_ops_t;

endpackage

`default_nettype wire

// ===== hdl/crh_query_if.sv =====
// Query channel: valid/ready handshake with one query request as payload.
// Depends on crh_pkg for the coordinate type.
`timescale 1ns / 1ps
`default_nettype none

interface crh_query_if;
  logic            valid;
  logic            ready;
  logic            action;
  crh_pkg::coord_t rect_min_x;
  crh_pkg::coord_t rect_min_z;
  crh_pkg::coord_t rect_max_x;
  crh_pkg::coord_t rect_max_z;
  crh_pkg::coord_t point_x;
  crh_pkg::coord_t point_y;
  crh_pkg::coord_t point_z;

  modport source (
    output valid, action, rect_min_x, rect_min_z, rect_max_x, rect_max_z,
           point_x, point_y, point_z,
    input  ready
  );

  modport sink (
    input  valid, action, rect_min_x, rect_min_z, rect_max_x, rect_max_z,
           point_x, point_y, point_z,
    output ready
  );
endinterface

`default_nettype wire

// ===== hdl/crh_result_if.sv =====
// Result channel: valid/ready handshake with the hit flag as payload.
// Standalone; no package types needed.
`timescale 1ns / 1ps
`default_nettype none

interface crh_result_if;
  logic valid;
  logic ready;
  logic hit;

  modport source (
    output valid, hit,
    input  ready
  );

  modport sink (
    input  valid, hit,
    output ready
  );
endinterface

`default_nettype wire

// ===== hdl/circle_rect_point_hit_test.sv =====
// Throughput: one request per cycle when the result side is ready; the four
// register stages are offsets, clamp, squares, and sum and compare into the
// output register. A stall holds each occupied stage until the stage after
// it frees up; empty stages still fill.
// Reset clears the zone registers to zero and empties every pipeline stage.
`timescale 1ns / 1ps
`default_nettype none

module circle_rect_point_hit_test (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [crh_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [crh_pkg::COORD_BITS-1:0]   cfg_wdata_i,
  crh_query_if.sink                             query_i,
  crh_result_if.source                          result_o
);

  typedef struct packed {
    logic          act;
    logic          ctr_in;
    crh_pkg::sq_t  sq0;
    crh_pkg::sq_t  sq1;
    crh_pkg::sq_t  sq2;
    crh_pkg::sq_t  sq3;
    crh_pkg::sq_t  sq4;
    crh_pkg::sq_t  sq5;
    crh_pkg::r2_t  r2;
  } s3_t;

  // Square of a signed offset; the result always fits the unsigned width.
  function automatic crh_pkg::sq_t square(crh_pkg::diff_t a);
    logic signed [2*crh_pkg::DIFF_W-1:0] p;
    p = a * a;
    return p[crh_pkg::SQ_W-1:0];
  endfunction

  crh_pkg::crh_cfg_t cfg_q;
  logic              ops_valid;
  logic              ops_ready;
  crh_pkg::crh_ops_t ops;
  logic              s3_valid_q;
  s3_t               s3_q;
  s3_t               s3_d;
  logic              s3_en;
  logic              out_valid_q;
  logic              hit_q;
  logic              hit_d;
  logic              out_en;
  crh_pkg::sum_t     r2_ext;
  crh_pkg::sum_t     d_bottom;
  crh_pkg::sum_t     d_top;
  crh_pkg::sum_t     d_right;
  crh_pkg::sum_t     d_left;
  crh_pkg::sum_t     d_point;

  // Zone configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        crh_pkg::CFG_CENTER_X:    cfg_q.center_x    <= cfg_wdata_i;
        crh_pkg::CFG_CENTER_Y:    cfg_q.center_y    <= cfg_wdata_i;
        crh_pkg::CFG_CENTER_Z:    cfg_q.center_z    <= cfg_wdata_i;
        crh_pkg::CFG_ZONE_RADIUS: cfg_q.zone_radius <= cfg_wdata_i[crh_pkg::RAD_W-1:0];
        default:                  cfg_q             <= cfg_q;
      endcase
    end
  end

  // Offset and clamp stages.
  crh_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .query_i     (query_i),
    .ops_valid_o (ops_valid),
    .ops_ready_i (ops_ready),
    .ops_o       (ops)
  );

  assign out_en    = !out_valid_q || result_o.ready;
  assign s3_en     = !s3_valid_q || out_en;
  assign ops_ready = s3_en;

  // Stage 3: squares of the operands and of the radius.
  always_comb begin
    s3_d.act    = ops.act;
    s3_d.ctr_in = ops.ctr_in;
    s3_d.sq0    = square(ops.op0);
    s3_d.sq1    = square(ops.op1);
    s3_d.sq2    = square(ops.op2);
    s3_d.sq3    = square(ops.op3);
    s3_d.sq4    = square(ops.op4);
    s3_d.sq5    = square(ops.op5);
    s3_d.r2     = crh_pkg::r2_t'(cfg_q.zone_radius) * crh_pkg::r2_t'(cfg_q.zone_radius);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else if (s3_en) begin
      s3_valid_q <= ops_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_en && ops_valid) begin
      s3_q <= s3_d;
    end
  end

  // Stage 4: squared distance to each edge, or to the point, against r^2; a rectangle that holds the center also hits.
  assign r2_ext   = crh_pkg::sum_t'(s3_q.r2);
  assign d_bottom = crh_pkg::sum_t'(s3_q.sq0) + crh_pkg::sum_t'(s3_q.sq2);
  assign d_top    = crh_pkg::sum_t'(s3_q.sq0) + crh_pkg::sum_t'(s3_q.sq3);
  assign d_right  = crh_pkg::sum_t'(s3_q.sq5) + crh_pkg::sum_t'(s3_q.sq1);
  assign d_left   = crh_pkg::sum_t'(s3_q.sq4) + crh_pkg::sum_t'(s3_q.sq1);
  assign d_point  = crh_pkg::sum_t'(s3_q.sq0) + crh_pkg::sum_t'(s3_q.sq1) +
                    crh_pkg::sum_t'(s3_q.sq2);

  always_comb begin
    if (s3_q.act == crh_pkg::ACT_RECT) begin
      hit_d = s3_q.ctr_in || (d_bottom <= r2_ext) || (d_top <= r2_ext) ||
              (d_right <= r2_ext) || (d_left <= r2_ext);
    end else begin
      hit_d = (d_point < r2_ext);
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_en) begin
      out_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_en && s3_valid_q) begin
      hit_q <= hit_d;
    end
  end

  assign result_o.valid = out_valid_q;
  assign result_o.hit   = hit_q;

`ifndef SYNTH
  // A rectangle that contains the center is always a hit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_en && s3_valid_q && s3_q.act == crh_pkg::ACT_RECT && s3_q.ctr_in |=> hit_q)
    else $error("crh: rectangle around the center reported no hit");

  // With zero radius no point lies strictly inside the sphere.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_en && s3_valid_q && s3_q.act == crh_pkg::ACT_POINT && s3_q.r2 == '0 |=> !hit_q)
    else $error("crh: point query hit a zero-radius sphere");

  // A request in the square stage moves to the output when it is free.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s3_valid_q && out_en |=> out_valid_q)
    else $error("crh: request dropped between square stage and output");
`endif

endmodule

`default_nettype wire

// ===== hdl/crh_front.sv =====
// Front two pipeline stages: offsets from the zone center, then edge clamping
// and operand selection for the square stage. Uses crh_pkg and crh_query_if.
`timescale 1ns / 1ps
`default_nettype none

module crh_front (
  input  wire                logic clk_i,
  input  wire                logic rst_ni,
  input  wire crh_pkg::crh_cfg_t cfg_i,
  crh_query_if.sink          query_i,
  output logic               ops_valid_o,
  input  wire                logic ops_ready_i,
  output crh_pkg::crh_ops_t  ops_o
);

  typedef struct packed {
    logic                act;
    logic                ctr_in;
    crh_pkg::diff_t      e0;
    crh_pkg::diff_t      e1;
    crh_pkg::diff_t      e2;
    crh_pkg::diff_t      e3;
  } s1_t;

  // Offset along one axis from the center to the closest point of the span
  // between two endpoint offsets; zero when the span covers the center.
  function automatic crh_pkg::diff_t clamp_off(crh_pkg::diff_t a, crh_pkg::diff_t b);
    crh_pkg::diff_t lo;
    crh_pkg::diff_t hi;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    if (lo > 0) begin
      return lo;
    end else if (hi < 0) begin
      return hi;
    end
    return '0;
  endfunction

  logic              s1_valid_q;
  s1_t               s1_q;
  s1_t               s1_d;
  logic              s1_en;
  logic              s2_valid_q;
  crh_pkg::crh_ops_t s2_q;
  crh_pkg::crh_ops_t s2_d;
  logic              s2_en;
  logic              is_rect;
  crh_pkg::coord_t   m0;
  crh_pkg::coord_t   m1;
  crh_pkg::coord_t   m2;
  crh_pkg::coord_t   c1;
  logic              s2_rect;
  crh_pkg::diff_t    ax;
  crh_pkg::diff_t    az;

  // Each stage loads when empty or when the stage after it moves on.
  assign s2_en         = !s2_valid_q || ops_ready_i;
  assign s1_en         = !s1_valid_q || s2_en;
  assign query_i.ready = s1_en;

  // Stage 1: offsets from the center and the center-in-rectangle flag; e0..e2 are shared between the two query kinds.
  assign is_rect = (query_i.action == crh_pkg::ACT_RECT);
  assign m0      = is_rect ? query_i.rect_min_x : query_i.point_x;
  assign m1      = is_rect ? query_i.rect_max_x : query_i.point_y;
  assign c1      = is_rect ? cfg_i.center_x     : cfg_i.center_y;
  assign m2      = is_rect ? query_i.rect_min_z : query_i.point_z;

  always_comb begin
    s1_d.act    = query_i.action;
    s1_d.ctr_in = (cfg_i.center_x >= query_i.rect_min_x) &&
                  (cfg_i.center_x <= query_i.rect_max_x) &&
                  (cfg_i.center_z >= query_i.rect_min_z) &&
                  (cfg_i.center_z <= query_i.rect_max_z);
    s1_d.e0     = crh_pkg::diff_t'(m0) - crh_pkg::diff_t'(cfg_i.center_x);
    s1_d.e1     = crh_pkg::diff_t'(m1) - crh_pkg::diff_t'(c1);
    s1_d.e2     = crh_pkg::diff_t'(m2) - crh_pkg::diff_t'(cfg_i.center_z);
    s1_d.e3     = crh_pkg::diff_t'(query_i.rect_max_z) -
                  crh_pkg::diff_t'(cfg_i.center_z);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_en) begin
      s1_valid_q <= query_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_en && query_i.valid) begin
      s1_q <= s1_d;
    end
  end

  // Stage 2: clamp the center onto each edge span and pick the operands.
  assign s2_rect = (s1_q.act == crh_pkg::ACT_RECT);
  assign ax      = clamp_off(s1_q.e0, s1_q.e1);
  assign az      = clamp_off(s1_q.e2, s1_q.e3);

  always_comb begin
    s2_d.act    = s1_q.act;
    s2_d.ctr_in = s1_q.ctr_in;
    s2_d.op0    = s2_rect ? ax : s1_q.e0;
    s2_d.op1    = s2_rect ? az : s1_q.e1;
    s2_d.op2    = s1_q.e2;
    s2_d.op3    = s1_q.e3;
    s2_d.op4    = s1_q.e0;
    s2_d.op5    = s1_q.e1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_en) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_en && s1_valid_q) begin
      s2_q <= s2_d;
    end
  end

  assign ops_valid_o = s2_valid_q;
  assign ops_o       = s2_q;

`ifndef SYNTH
  // An accepted request always lands in stage 1.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    query_i.valid && query_i.ready |=> s1_valid_q)
    else $error("crh_front: accepted request did not enter stage 1");

  // A stalled stage 1 keeps its request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s2_en |=> s1_valid_q && $stable(s1_q))
    else $error("crh_front: stage 1 lost or changed a stalled request");

  // A stalled stage 2 keeps its operands.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q && !ops_ready_i |=> s2_valid_q && $stable(s2_q))
    else $error("crh_front: stage 2 lost or changed a stalled request");
`endif

endmodule

`default_nettype wire
